FILE: rtl/cpm_pkg.sv
// cpm_pkg: shared types and constants for the command pattern matcher
// used by cpm_ctrl, cpm_datapath and command_pattern_matcher_unit
// no dependencies
package cpm_pkg;

  // pattern storage geometry fixed by the four 64-bit pattern words
  localparam int CFG_REGS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CHARS_PER_WORD = 8;
  localparam int MAX_CHARS  = CFG_REGS * CHARS_PER_WORD;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] MS_MATCH      = 2'd0;
  localparam logic [STATUS_W-1:0] MS_INCOMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] MS_MISMATCH   = 2'd2;

  // special pattern characters
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_CHKEND
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load_item;
    logic                rd_q;
    logic                pos_inc;
    logic                pos_from_q;
    logic                q_init;
    logic                q_inc;
    logic                hit_set;
    logic                cnt_inc;
    logic                res_load;
    logic                res_plus1;
    logic [STATUS_W-1:0] res_status;
  } cpm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pch_zero;
    logic pch_eq;
    logic pch_qmark;
    logic pch_lbrace;
    logic pch_rbrace;
    logic chr_digit;
    logic hit;
    logic last;
    logic fin;
    logic out_busy;
  } cpm_stat_t;

endpackage

FILE: rtl/cpm_datapath.sv
// cpm_datapath: pattern storage, match position/count registers and result register
// depends on cpm_pkg; driven by cpm_ctrl commands
module cpm_datapath
  import cpm_pkg::*;
#(
  parameter int PATTERN_CHARS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [CHAR_W-1:0]     in_check_char,
  input  logic                  in_first_char,
  input  logic                  in_last_char,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_match_status,
  output logic [POS_W-1:0]      out_char_count,
  input  cpm_cmd_t              cmd,
  output cpm_stat_t             stat
);

  localparam int PAT_LEN = (PATTERN_CHARS < MAX_CHARS) ? PATTERN_CHARS : MAX_CHARS;
  localparam int PIDX_W  = $clog2(PAT_LEN);

  logic [CHAR_W-1:0]   pat_r [PAT_LEN];
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    cnt_r;
  logic [POS_W-1:0]    q_r;
  logic                hit_r;
  logic [CHAR_W-1:0]   chr_r;
  logic                last_r;
  logic                fin_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_count_r;
  logic [POS_W-1:0]    rd_addr;
  logic [CHAR_W-1:0]   pch;

  // pattern bytes, cleared at reset, written a whole word at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < PAT_LEN; b++) begin
        pat_r[b] <= CH_NUL;
      end
    end else if (cfg_wr_en) begin
      for (int b = 0; b < PAT_LEN; b++) begin
        if (cfg_index == CFG_IDX_W'(b / CHARS_PER_WORD)) begin
          pat_r[b] <= cfg_wdata[(b % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
        end
      end
    end
  end

  // single pattern read port, positions past storage read as terminator
  assign rd_addr = cmd.rd_q ? q_r : pos_r;

  always_comb begin
    if (rd_addr < POS_W'(PAT_LEN)) begin
      pch = pat_r[rd_addr[PIDX_W-1:0]];
    end else begin
      pch = CH_NUL;
    end
  end

  // status toward the controller
  always_comb begin
    stat.pch_zero   = (pch == CH_NUL);
    stat.pch_eq     = (pch == chr_r);
    stat.pch_qmark  = (pch == CH_QMARK);
    stat.pch_lbrace = (pch == CH_LBRACE);
    stat.pch_rbrace = (pch == CH_RBRACE);
    stat.chr_digit  = (chr_r >= CH_ZERO) && (chr_r <= CH_NINE);
    stat.hit        = hit_r;
    stat.last       = last_r;
    stat.fin        = fin_r;
    stat.out_busy   = out_valid_r && out_stall;
  end

  // received character and last mark
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      chr_r  <= in_check_char;
      last_r <= in_last_char;
    end
  end

  // group scan pointer and hit flag
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      q_r   <= pos_r + POS_W'(1);
      hit_r <= 1'b0;
    end else begin
      if (cmd.q_inc) begin
        q_r <= q_r + POS_W'(1);
      end
      if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
    end
  end

  // match position, consumed count and finished flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      fin_r <= 1'b1;
    end else begin
      if (cmd.load_item && in_first_char) begin
        pos_r <= '0;
        cnt_r <= '0;
        fin_r <= 1'b0;
      end else begin
        if (cmd.pos_inc) begin
          pos_r <= pos_r + POS_W'(1);
        end else if (cmd.pos_from_q) begin
          pos_r <= q_r + POS_W'(1);
        end
        if (cmd.cnt_inc) begin
          cnt_r <= cnt_r + POS_W'(1);
        end
        if (cmd.res_load) begin
          fin_r <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_count_r  <= cmd.res_plus1 ? (cnt_r + POS_W'(1)) : cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_status = out_status_r;
  assign out_char_count   = out_count_r;

endmodule

FILE: rtl/cpm_ctrl.sv
// cpm_ctrl: state machine sequencing one received character through the pattern
// depends on cpm_pkg; commands cpm_datapath
module cpm_ctrl
  import cpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_first_char,
  output logic      in_stall,
  input  cpm_stat_t stat,
  output cpm_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (in_first_char || !stat.fin)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.pch_zero) begin
          if (!stat.out_busy) state_nxt = S_IDLE;
        end else if (stat.pch_eq || (stat.pch_qmark && stat.chr_digit)) begin
          state_nxt = S_CHKEND;
        end else if (stat.pch_lbrace) begin
          state_nxt = S_SCAN;
        end else if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.pch_zero) begin
          if (!stat.out_busy) state_nxt = S_IDLE;
        end else if (stat.pch_eq) begin
          state_nxt = S_SCAN;
        end else if (stat.pch_rbrace) begin
          if (stat.hit) begin
            state_nxt = S_CHKEND;
          end else if (!stat.out_busy) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHKEND: begin
        if (stat.pch_zero || stat.last) begin
          if (!stat.out_busy) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      S_EVAL: begin
        if (stat.pch_zero) begin
          cmd.res_load   = !stat.out_busy;
          cmd.res_status = MS_MATCH;
        end else if (stat.pch_eq || (stat.pch_qmark && stat.chr_digit)) begin
          cmd.pos_inc = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else if (stat.pch_lbrace) begin
          cmd.q_init = 1'b1;
        end else begin
          cmd.res_load   = !stat.out_busy;
          cmd.res_status = MS_MISMATCH;
          cmd.res_plus1  = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.rd_q = 1'b1;
        if (stat.pch_zero) begin
          cmd.res_load   = !stat.out_busy;
          cmd.res_status = MS_MISMATCH;
          cmd.res_plus1  = 1'b1;
        end else if (stat.pch_eq) begin
          cmd.hit_set = 1'b1;
          cmd.q_inc   = 1'b1;
        end else if (stat.pch_rbrace) begin
          if (stat.hit) begin
            cmd.pos_from_q = 1'b1;
            cmd.cnt_inc    = 1'b1;
          end else begin
            cmd.res_load   = !stat.out_busy;
            cmd.res_status = MS_MISMATCH;
            cmd.res_plus1  = 1'b1;
          end
        end else begin
          cmd.q_inc = 1'b1;
        end
      end
      S_CHKEND: begin
        if (stat.pch_zero) begin
          cmd.res_load   = !stat.out_busy;
          cmd.res_status = MS_MATCH;
        end else if (stat.last) begin
          cmd.res_load   = !stat.out_busy;
          cmd.res_status = MS_INCOMPLETE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/command_pattern_matcher_unit.sv
// command_pattern_matcher_unit: top level of the command pattern matcher
// depends on cpm_pkg, cpm_ctrl and cpm_datapath
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   in       | input     | in_valid/in_stall  | in_check_char, in_first_char, in_last_char
//   out      | output    | out_valid/out_stall| out_match_status, out_char_count
//   cfg      | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// after acceptance a matching literal or '?' goes from evaluation through the end check
// to idle, a mismatch or an exhausted pattern returns from evaluation, an ignored one stays
// idle; a brace group scans pattern characters up to and including the closing brace.
// rst_n is synchronous active low; it clears the pattern store, state machine, position,
// count and result valid, and leaves the matcher waiting for a transaction marked first.
// a pending result does not block acceptance; only when a new result is due while
// the previous one is still stalled does the controller hold in place.
module command_pattern_matcher_unit
  import cpm_pkg::*;
#(
  parameter int PATTERN_CHARS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_check_char,
  input  logic                  in_first_char,
  input  logic                  in_last_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_match_status,
  output logic [POS_W-1:0]      out_char_count
);

  cpm_cmd_t  cmd;
  cpm_stat_t stat;

  // sequencing
  cpm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_first_char (in_first_char),
    .in_stall      (in_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  // storage and result path
  cpm_datapath #(
    .PATTERN_CHARS (PATTERN_CHARS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_check_char    (in_check_char),
    .in_first_char    (in_first_char),
    .in_last_char     (in_last_char),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_match_status (out_match_status),
    .out_char_count   (out_char_count),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
